[hdl/mpp_pkg.sv]
// ----------------------------------------------------------------------------
// mpp_pkg: shared types and constants of the max-plus matrix power unit
// Entry format, action codes, bank identifiers and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mpp_pkg;

    localparam int MAX_STATES_DEF = 32;

    localparam int SIZE_W = 6;
    localparam int IDX_PORT_W = 5;
    localparam int WGT_W = 16;
    localparam int EXP_W = 48;
    localparam int VAL_W = 62;
    localparam int ENT_W = VAL_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // action codes of an input word
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // storage banks: three rotating work banks and the edge bank
    localparam int NUM_BANKS = 4;
    localparam logic [1:0] BANK_W0 = 2'd0;
    localparam logic [1:0] BANK_W1 = 2'd1;
    localparam logic [1:0] BANK_W2 = 2'd2;
    localparam logic [1:0] BANK_EDGE = 2'd3;

    typedef struct packed {
        logic       mul;       // multiply step issued this cycle
        logic       rd;        // result read issued this cycle
        logic       first;     // first term of a dot product
        logic       last;      // last term of a dot product
        logic       a_ident;   // left operand is the identity matrix
        logic       diag;      // identity diagonal hit for this term or read
        logic       rd_area;   // read lies inside the computed square
        logic [1:0] a_bank;
        logic [1:0] b_bank;
        logic [1:0] dst_bank;
        logic       edge_we;   // load one edge entry
        logic       edge_clr;  // clear one edge entry
    } mpp_cmd_t;

    typedef struct packed {
        logic out_full;        // output word waits to be taken
    } mpp_sts_t;

endpackage

[hdl/mpp_ram.sv]
// ----------------------------------------------------------------------------
// mpp_ram: matrix storage bank
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mpp_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [mpp_pkg::ENT_W-1:0] wdata,
    input  logic [AW-1:0]           raddr_a,
    input  logic [AW-1:0]           raddr_b,
    output logic [mpp_pkg::ENT_W-1:0] rdata_a,
    output logic [mpp_pkg::ENT_W-1:0] rdata_b
);
    import mpp_pkg::*;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;

    // write one entry, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

[hdl/mpp_datapath.sv]
// ----------------------------------------------------------------------------
// mpp_datapath: banks, saturating add and max accumulation
// Reads two operands per cycle, adds them with saturation, folds the sums of
// one dot product into a running maximum and writes it back; also forms the
// output word of a read.
// ----------------------------------------------------------------------------
module mpp_datapath #(
    parameter int MAX_STATES = mpp_pkg::MAX_STATES_DEF,
    localparam int DEPTH = MAX_STATES * MAX_STATES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mpp_pkg::mpp_cmd_t         cmd,
    input  logic [AW-1:0]             a_addr,
    input  logic [AW-1:0]             b_addr,
    input  logic [AW-1:0]             d_addr,
    input  logic [AW-1:0]             e_addr,
    input  logic                      edge_present,
    input  logic [mpp_pkg::WGT_W-1:0] weight,
    output mpp_pkg::mpp_sts_t         sts,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      reachable,
    output logic [mpp_pkg::VAL_W-1:0] value
);
    import mpp_pkg::*;

    logic [ENT_W-1:0] rda [NUM_BANKS];
    logic [ENT_W-1:0] rdb [NUM_BANKS];
    logic [ENT_W-1:0] e_wdata;
    logic             e_we;

    // stage 1: operands arrive from the banks
    logic             s1_mul_reg;
    logic             s1_rd_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_ident_reg;
    logic             s1_diag_reg;
    logic             s1_area_reg;
    logic [1:0]       s1_a_bank_reg;
    logic [1:0]       s1_b_bank_reg;
    logic [1:0]       s1_dst_bank_reg;
    logic [AW-1:0]    s1_dst_reg;

    // stage 2: saturated sum
    logic             s2_mul_reg;
    logic             s2_first_reg;
    logic             s2_last_reg;
    logic [1:0]       s2_dst_bank_reg;
    logic [AW-1:0]    s2_dst_reg;
    logic             s2_ok_reg;
    logic [VAL_W-1:0] s2_sum_reg;

    logic             acc_ok_reg;
    logic [VAL_W-1:0] acc_val_reg;
    logic             acc_ok_next;
    logic [VAL_W-1:0] acc_val_next;

    logic             out_valid_reg;
    logic             out_reach_reg;
    logic [VAL_W-1:0] out_val_reg;

    logic [ENT_W-1:0] a_ent;
    logic [ENT_W-1:0] b_ent;
    logic             a_ok;
    logic [VAL_W-1:0] a_val;
    logic [VAL_W:0]   sum_wide;
    logic [VAL_W-1:0] sum_sat;
    logic             rd_reach;

    // edge bank write: clear sweep or load
    assign e_we = cmd.edge_we | cmd.edge_clr;
    assign e_wdata = (cmd.edge_we && edge_present) ?
                     {1'b1, {(VAL_W - WGT_W){1'b0}}, weight} : '0;

    genvar gb;
    generate
        for (gb = 0; gb < NUM_BANKS; gb++)
        begin : g_bank
            logic bank_we;
            logic [AW-1:0] bank_waddr;
            logic [ENT_W-1:0] bank_wdata;
            if (gb == int'(BANK_EDGE))
            begin : g_edge
                assign bank_we = e_we;
                assign bank_waddr = e_addr;
                assign bank_wdata = e_wdata;
            end
            else
            begin : g_work
                assign bank_we = s2_mul_reg && s2_last_reg && (s2_dst_bank_reg == 2'(gb));
                assign bank_waddr = s2_dst_reg;
                assign bank_wdata = {acc_ok_next, acc_val_next};
            end
            mpp_ram #(.DEPTH(DEPTH)) u_ram (
                .clk     (clk),
                .we      (bank_we),
                .waddr   (bank_waddr),
                .wdata   (bank_wdata),
                .raddr_a (a_addr),
                .raddr_b (b_addr),
                .rdata_a (rda[gb]),
                .rdata_b (rdb[gb])
            );
        end
    endgenerate

    // stage 1 and stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_mul_reg <= 1'b0;
            s1_rd_reg <= 1'b0;
            s2_mul_reg <= 1'b0;
        end
        else
        begin
            s1_mul_reg <= cmd.mul;
            s1_rd_reg <= cmd.rd;
            s2_mul_reg <= s1_mul_reg;
        end
    end

    // tags that travel with the operands
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg <= cmd.last;
        s1_ident_reg <= cmd.a_ident;
        s1_diag_reg <= cmd.diag;
        s1_area_reg <= cmd.rd_area;
        s1_a_bank_reg <= cmd.a_bank;
        s1_b_bank_reg <= cmd.b_bank;
        s1_dst_bank_reg <= cmd.dst_bank;
        s1_dst_reg <= d_addr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg <= s1_last_reg;
        s2_dst_bank_reg <= s1_dst_bank_reg;
        s2_dst_reg <= s1_dst_reg;
        s2_ok_reg <= a_ok & b_ent[VAL_W];
        s2_sum_reg <= sum_sat;
    end

    // select operands and add with saturation
    always_comb
    begin
        a_ent = rda[s1_a_bank_reg];
        b_ent = rdb[s1_b_bank_reg];
        a_ok = s1_ident_reg ? s1_diag_reg : a_ent[VAL_W];
        a_val = s1_ident_reg ? '0 : a_ent[VAL_W-1:0];
        sum_wide = {1'b0, a_val} + {1'b0, b_ent[VAL_W-1:0]};
        sum_sat = sum_wide[VAL_W] ? '1 : sum_wide[VAL_W-1:0];
        rd_reach = s1_ident_reg ? (s1_diag_reg & s1_area_reg)
                                : (s1_area_reg & a_ent[VAL_W]);
    end

    // fold the new term into the running maximum
    always_comb
    begin
        acc_ok_next = acc_ok_reg;
        acc_val_next = acc_val_reg;
        if (s2_first_reg)
        begin
            acc_ok_next = s2_ok_reg;
            acc_val_next = s2_sum_reg;
        end
        else if (s2_ok_reg && (!acc_ok_reg || (s2_sum_reg > acc_val_reg)))
        begin
            acc_ok_next = 1'b1;
            acc_val_next = s2_sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_mul_reg)
        begin
            acc_ok_reg <= acc_ok_next;
            acc_val_reg <= acc_val_next;
        end
    end

    // output word: load on a read, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_rd_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rd_reg)
        begin
            out_reach_reg <= rd_reach;
            out_val_reg <= rd_reach ? (s1_ident_reg ? '0 : a_ent[VAL_W-1:0]) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign reachable = out_reach_reg;
    assign value = out_val_reg;
    assign sts.out_full = out_valid_reg;

endmodule

[hdl/mpp_ctrl.sv]
// ----------------------------------------------------------------------------
// mpp_ctrl: sequencer of the max-plus matrix power unit
// Clears the edge bank after reset, takes input words, walks the exponent
// bits and issues one multiply term per cycle over the active square.
// ----------------------------------------------------------------------------
module mpp_ctrl #(
    parameter int MAX_STATES = mpp_pkg::MAX_STATES_DEF,
    localparam int DEPTH = MAX_STATES * MAX_STATES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mpp_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [mpp_pkg::IDX_PORT_W-1:0] row,
    input  logic [mpp_pkg::IDX_PORT_W-1:0] col,
    input  logic [mpp_pkg::EXP_W-1:0]      exponent,
    input  mpp_pkg::mpp_sts_t              sts,
    output mpp_pkg::mpp_cmd_t              cmd,
    output logic [AW-1:0]                  a_addr,
    output logic [AW-1:0]                  b_addr,
    output logic [AW-1:0]                  d_addr,
    output logic [AW-1:0]                  e_addr
);
    import mpp_pkg::*;

    localparam int IW = $clog2(MAX_STATES);
    localparam int NW = $clog2(MAX_STATES + 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_PLAN  = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_DRAIN = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        K_INIT = 3'b001,
        K_PMUL = 3'b010,
        K_SQ   = 3'b100
    } kind_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [SIZE_W-1:0] size_reg;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     n_act;
    logic [EXP_W-1:0]  rem_reg, rem_next;
    logic              init_reg, init_next;
    logic              pid_reg, pid_next;
    logic [1:0]        p_reg, p_next;
    logic [1:0]        s_reg, s_next;
    logic [1:0]        t_reg, t_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [1:0]        drain_reg, drain_next;

    logic              accept;
    logic              in_range;
    logic [IW-1:0]     row_idx;
    logic [IW-1:0]     col_idx;
    logic              last_i;
    logic              last_j;
    logic              last_k;

    function automatic logic [AW-1:0] entry_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        entry_addr = AW'(r) * AW'(MAX_STATES) + AW'(c);
    endfunction

    // clamp the configured size to the storage, a size of zero counting as one
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (int'(size_reg) > MAX_STATES)
        begin
            n_act = NW'(MAX_STATES);
        end
        else
        begin
            n_act = NW'(size_reg);
        end
    end

    assign in_stall = (state_reg != ST_IDLE) || sts.out_full;
    assign accept = in_valid && !in_stall;
    assign in_range = (int'(row) < MAX_STATES) && (int'(col) < MAX_STATES);
    assign row_idx = IW'(row);
    assign col_idx = IW'(col);
    assign last_k = (NW'(k_reg) + NW'(1)) == n_reg;
    assign last_j = (NW'(j_reg) + NW'(1)) == n_reg;
    assign last_i = (NW'(i_reg) + NW'(1)) == n_reg;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg <= K_INIT;
            clr_reg <= '0;
            n_reg <= NW'(MAX_STATES);
            rem_reg <= '0;
            init_reg <= 1'b0;
            pid_reg <= 1'b1;
            p_reg <= BANK_W0;
            s_reg <= BANK_W1;
            t_reg <= BANK_W2;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            clr_reg <= clr_next;
            n_reg <= n_next;
            rem_reg <= rem_next;
            init_reg <= init_next;
            pid_reg <= pid_next;
            p_reg <= p_next;
            s_reg <= s_next;
            t_reg <= t_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        clr_next = clr_reg;
        n_next = n_reg;
        rem_next = rem_reg;
        init_next = init_reg;
        pid_next = pid_reg;
        p_next = p_reg;
        s_next = s_reg;
        t_next = t_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        drain_next = drain_reg;
        cmd = '0;
        a_addr = '0;
        b_addr = '0;
        d_addr = '0;
        e_addr = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the edge bank to minus infinity
                cmd.edge_clr = 1'b1;
                e_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_LOAD:
                        begin
                            cmd.edge_we = in_range;
                            e_addr = entry_addr(row_idx, col_idx);
                        end
                        ACT_COMPUTE:
                        begin
                            n_next = n_act;
                            rem_next = exponent;
                            init_next = (exponent != '0);
                            pid_next = 1'b1;
                            state_next = ST_PLAN;
                        end
                        ACT_READ:
                        begin
                            cmd.rd = 1'b1;
                            cmd.a_bank = p_reg;
                            cmd.a_ident = pid_reg;
                            cmd.diag = (row == col);
                            cmd.rd_area = (int'(row) < int'(n_reg)) &&
                                          (int'(col) < int'(n_reg));
                            a_addr = entry_addr(row_idx, col_idx);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_PLAN:
            begin
                // pick the next product: edge copy, power update or squaring; back to idle when the exponent is used up
                i_next = '0;
                j_next = '0;
                k_next = '0;
                priority if (init_reg)
                begin
                    init_next = 1'b0;
                    kind_next = K_INIT;
                    state_next = ST_MUL;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (rem_reg[0])
                begin
                    kind_next = K_PMUL;
                    state_next = ST_MUL;
                end
                else
                begin
                    kind_next = K_SQ;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // issue one term of dst(i,j) = max over k of a(i,k) + b(k,j)
                cmd.mul = 1'b1;
                cmd.first = (k_reg == '0);
                cmd.last = last_k;
                cmd.dst_bank = t_reg;
                cmd.diag = (i_reg == k_reg);
                cmd.a_bank = (kind_reg == K_SQ) ? s_reg : p_reg;
                cmd.a_ident = (kind_reg == K_INIT) || ((kind_reg == K_PMUL) && pid_reg);
                cmd.b_bank = (kind_reg == K_INIT) ? BANK_EDGE : s_reg;
                a_addr = entry_addr(i_reg, k_reg);
                b_addr = entry_addr(k_reg, j_reg);
                d_addr = entry_addr(i_reg, j_reg);
                k_next = k_reg + IW'(1);
                if (last_k)
                begin
                    k_next = '0;
                    j_next = j_reg + IW'(1);
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + IW'(1);
                        if (last_i)
                        begin
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // wait for the last write, then rotate the banks
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd2)
                begin
                    state_next = ST_PLAN;
                    if (kind_reg == K_PMUL)
                    begin
                        p_next = t_reg;
                        t_next = p_reg;
                        pid_next = 1'b0;
                        rem_next = {rem_reg[EXP_W-1:1], 1'b0};
                    end
                    else
                    begin
                        s_next = t_reg;
                        t_next = s_reg;
                        if (kind_reg == K_SQ)
                        begin
                            rem_next = {1'b0, rem_reg[EXP_W-1:1]};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/max_plus_matrix_power_unit.sv]
// ----------------------------------------------------------------------------
// max_plus_matrix_power_unit: tropical matrix power by square-and-multiply
// Loads edge entries, raises the matrix to a power in the max-plus semiring
// and returns single entries of the result.
// ----------------------------------------------------------------------------
// After reset the unit clears its edge store, one entry a cycle, over all
// MAX_STATES*MAX_STATES entries (1024 at the default) and holds in_stall
// high meanwhile. A load word writes one edge entry if row and col are in
// range. A read word's result sits in an output register until taken; the
// next word waits for that. A compute word with a nonzero exponent e over an
// active size n runs (1 + popcount(e) + floor(log2(e))) matrix products, each
// of n*n*n terms on a single add-and-max unit fed by two bank read ports,
// with a pipeline drain and a bank rotation after each product; an exponent
// of zero runs no product. Entries outside the active size read as
// unreachable.
module max_plus_matrix_power_unit #(
    parameter int MAX_STATES = mpp_pkg::MAX_STATES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mpp_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [mpp_pkg::IDX_PORT_W-1:0] row,
    input  logic [mpp_pkg::IDX_PORT_W-1:0] col,
    input  logic                           edge_present,
    input  logic [mpp_pkg::WGT_W-1:0]      weight,
    input  logic [mpp_pkg::EXP_W-1:0]      exponent,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           reachable,
    output logic [mpp_pkg::VAL_W-1:0]      value
);
    import mpp_pkg::*;

    localparam int AW = $clog2(MAX_STATES * MAX_STATES);

    mpp_cmd_t      cmd;
    mpp_sts_t      sts;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] d_addr;
    logic [AW-1:0] e_addr;

    mpp_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .row       (row),
        .col       (col),
        .exponent  (exponent),
        .sts       (sts),
        .cmd       (cmd),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .d_addr    (d_addr),
        .e_addr    (e_addr)
    );

    mpp_datapath #(.MAX_STATES(MAX_STATES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .a_addr       (a_addr),
        .b_addr       (b_addr),
        .d_addr       (d_addr),
        .e_addr       (e_addr),
        .edge_present (edge_present),
        .weight       (weight),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reachable    (reachable),
        .value        (value)
    );

endmodule
